// ===== design/assert_macros.svh =====
// Assertion macros used by the mbm_regs module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define MBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define MBM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/mbm_pkg.sv =====
package mbm_pkg;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_PRG   = 2'd2,
    ACT_CHR   = 2'd3
  } action_e_t;

  // Register decode: address AND DECODE_MASK selects the register.
  localparam logic [15:0] DECODE_MASK     = 16'hE001;
  localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
  localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
  localparam logic [15:0] REG_MIRROR      = 16'hA000;
  localparam logic [15:0] REG_BLOCK       = 16'hA001;
  localparam logic [15:0] REG_IRQ_COUNT   = 16'hC000;
  localparam logic [15:0] REG_IRQ_LATCH   = 16'hC001;
  localparam logic [15:0] REG_IRQ_OFF     = 16'hE000;
  localparam logic [15:0] REG_IRQ_ON      = 16'hE001;

  // Bits of the bank select register and fixed banks.
  localparam int unsigned CHR_SWAP_BIT = 7;
  localparam int unsigned PRG_SWAP_BIT = 6;
  localparam logic [7:0]  FIXED_BANK_A = 8'd14;
  localparam logic [7:0]  FIXED_BANK_B = 8'd15;
  localparam logic [7:0]  PAIR_MASK    = 8'hFE;
  localparam logic [2:0]  BLOCK_TOP    = 3'd7;
  localparam logic [2:0]  BLOCK_LIMIT  = 3'd6;

  localparam int unsigned ROM_W = 22;

  // Architectural state of the mapper.
  typedef struct packed {
    logic [7:0]      bank_select;
    logic [2:0]      block_number;
    logic [1:0][7:0] program_bank;
    logic [5:0][7:0] char_bank;
    logic [7:0]      irq_count;
    logic [7:0]      irq_reload;
    logic            irq_on;
    logic            mirror_mode;
  } mbm_state_t;

  localparam mbm_state_t STATE_RESET = '{
    bank_select:  8'd0,
    block_number: 3'd0,
    program_bank: {8'd1, 8'd0},
    char_bank:    {8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0},
    irq_count:    8'd0,
    irq_reload:   8'd0,
    irq_on:       1'b0,
    mirror_mode:  1'b0
  };

endpackage

// ===== design/mbm_regs.sv =====
`include "assert_macros.svh"

module mbm_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  mbm_pkg::action_e_t  action,
  input  logic [15:0]         address,
  input  logic [7:0]          value,
  input  logic                in_vblank,
  output mbm_pkg::mbm_state_t st,
  output logic                irq_pulse,
  output logic                mirror_next
);
  import mbm_pkg::*;

  mbm_state_t st_next;
  logic [2:0] sel;

  // Register writes and the scanline counter.
  always_comb begin
    st_next   = st;
    irq_pulse = 1'b0;
    sel       = st.bank_select[2:0];
    if (fire) begin
      case (action)
        ACT_WRITE: begin
          if (address[15]) begin
            case (address & DECODE_MASK)
              REG_BANK_SELECT: st_next.bank_select = value;
              REG_BANK_DATA: begin
                if (sel < 3'd2) begin
                  st_next.char_bank[sel] = value & PAIR_MASK;
                end else if (sel < 3'd6) begin
                  st_next.char_bank[sel] = value;
                end else begin
                  st_next.program_bank[sel[0]] = value;
                end
              end
              REG_MIRROR: st_next.mirror_mode = value[0];
              REG_BLOCK: begin
                st_next.block_number = (value[2:0] == BLOCK_TOP) ? BLOCK_LIMIT : value[2:0];
              end
              REG_IRQ_COUNT: st_next.irq_count  = value;
              REG_IRQ_LATCH: st_next.irq_reload = value;
              REG_IRQ_OFF:   st_next.irq_on     = 1'b0;
              default:       st_next.irq_on     = 1'b1;
            endcase
          end
        end
        ACT_TICK: begin
          if (!in_vblank && st.irq_on) begin
            if (st.irq_count == 8'd0) begin
              st_next.irq_count = st.irq_reload;
              irq_pulse         = 1'b1;
            end else begin
              st_next.irq_count = st.irq_count - 8'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign mirror_next = st_next.mirror_mode;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else begin
      st <= st_next;
    end
  end

  `MBM_ASSERT(a_pulse_reload, irq_pulse |=> (st.irq_count == $past(st.irq_reload)), "pulse without reload")
  `MBM_ASSERT(a_block_range, st.block_number != BLOCK_TOP, "block number seven stored")
  `MBM_ASSERT(a_pair_even, !st.char_bank[0][0] && !st.char_bank[1][0], "paired bank is odd")

endmodule

// ===== design/mbm_xlate.sv =====
module mbm_xlate (
  input  mbm_pkg::mbm_state_t       st,
  input  mbm_pkg::action_e_t        action,
  input  logic [15:0]               address,
  output logic [mbm_pkg::ROM_W-1:0] rom_address
);
  import mbm_pkg::*;

  logic [1:0]  pwin;
  logic [7:0]  pbank;
  logic [8:0]  pbank_full;
  logic [2:0]  cwin;
  logic [7:0]  cbase;
  logic [11:0] cbank_full;

  // Program windows: 8K each, swap mode moves the fixed bank 14.
  always_comb begin
    pwin = address[14:13];
    if (st.bank_select[PRG_SWAP_BIT]) begin
      case (pwin)
        2'd0:    pbank = FIXED_BANK_A;
        2'd1:    pbank = st.program_bank[1];
        2'd2:    pbank = st.program_bank[0];
        default: pbank = FIXED_BANK_B;
      endcase
    end else begin
      case (pwin)
        2'd0:    pbank = st.program_bank[0];
        2'd1:    pbank = st.program_bank[1];
        2'd2:    pbank = FIXED_BANK_A;
        default: pbank = FIXED_BANK_B;
      endcase
    end
    pbank_full = {1'b0, pbank} + {2'b00, st.block_number, 4'b0000};
  end

  // Character windows: 1K each, the paired banks serve the low half, or the high half in swap mode.
  always_comb begin
    cwin = address[12:10] ^ {st.bank_select[CHR_SWAP_BIT], 2'b00};
    if (!cwin[2]) begin
      cbase = st.char_bank[{2'b00, cwin[1]}];
    end else begin
      cbase = st.char_bank[cwin - 3'd2];
    end
    cbank_full = {4'b0000, cbase} + {11'd0, !cwin[2] && cwin[0]}
               + {2'b00, st.block_number, 7'd0};
  end

  always_comb begin
    case (action)
      ACT_PRG: rom_address = address[15] ? {pbank_full, address[12:0]} : '0;
      ACT_CHR: rom_address = {cbank_full, address[9:0]};
      default: rom_address = '0;
    endcase
  end

endmodule

// ===== design/multicart_bank_mapper_irq_core.sv =====
// Channel  Dir  Beat contents (low bit first)
// s        in   tdata: address[15:0], value[23:16], in_vblank[24]; tuser: action[1:0]
// m        out  tdata: rom_address[21:0], irq_pulse[22], mirror_horizontal[23]
//
// Each item passes the input register, then the result register; one item per cycle
// sustained while m_tready stays high. The input register feeds the register file and
// address translation, which fill the result register. Reset (rst, synchronous)
// restores the power-up bank layout. A stalled output holds the result register; the
// input register still takes a beat while it is empty.
module multicart_bank_mapper_irq_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // address, value, in_vblank, zero pad
  input  logic [1:0]  s_tuser,  // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // rom_address, irq_pulse, mirror_horizontal
);
  import mbm_pkg::*;

  logic               in_valid;
  action_e_t          in_action;
  logic [15:0]        in_address;
  logic [7:0]         in_value;
  logic               in_vblank;
  logic               advance;
  logic               fire;
  mbm_state_t         st;
  logic               irq_pulse;
  logic               mirror_next;
  logic [ROM_W-1:0]   rom_address;
  logic [23:0]        out_data;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign fire     = in_valid && advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action  <= action_e_t'(s_tuser);
      in_address <= s_tdata[15:0];
      in_value   <= s_tdata[23:16];
      in_vblank  <= s_tdata[24];
    end
  end

  mbm_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .action      (in_action),
    .address     (in_address),
    .value       (in_value),
    .in_vblank   (in_vblank),
    .st          (st),
    .irq_pulse   (irq_pulse),
    .mirror_next (mirror_next)
  );

  mbm_xlate u_xlate (
    .st          (st),
    .action      (in_action),
    .address     (in_address),
    .rom_address (rom_address)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= {mirror_next, irq_pulse, rom_address};
    end
  end

  assign m_tdata = out_data;

endmodule
